// File: hw/rtl/lxu_pkg.sv
package lxu_pkg;

    // Opcode encoding of the decoded instruction
    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_ADDS  = 6'd1;
    localparam logic [5:0] OP_AND   = 6'd2;
    localparam logic [5:0] OP_ANDS  = 6'd3;
    localparam logic [5:0] OP_EOR   = 6'd4;
    localparam logic [5:0] OP_LSL   = 6'd5;
    localparam logic [5:0] OP_LSR   = 6'd6;
    localparam logic [5:0] OP_ORR   = 6'd7;
    localparam logic [5:0] OP_SUB   = 6'd8;
    localparam logic [5:0] OP_SUBS  = 6'd9;
    localparam logic [5:0] OP_BR    = 6'd10;
    localparam logic [5:0] OP_ADDI  = 6'd11;
    localparam logic [5:0] OP_ADDIS = 6'd12;
    localparam logic [5:0] OP_ANDI  = 6'd13;
    localparam logic [5:0] OP_ANDIS = 6'd14;
    localparam logic [5:0] OP_EORI  = 6'd15;
    localparam logic [5:0] OP_ORRI  = 6'd16;
    localparam logic [5:0] OP_SUBI  = 6'd17;
    localparam logic [5:0] OP_SUBIS = 6'd18;
    localparam logic [5:0] OP_B     = 6'd19;
    localparam logic [5:0] OP_BL    = 6'd20;
    localparam logic [5:0] OP_CBZ   = 6'd21;
    localparam logic [5:0] OP_CBNZ  = 6'd22;
    localparam logic [5:0] OP_BNE   = 6'd23;
    localparam logic [5:0] OP_BEQ   = 6'd24;
    localparam logic [5:0] OP_BLT   = 6'd25;
    localparam logic [5:0] OP_BLE   = 6'd26;
    localparam logic [5:0] OP_BGT   = 6'd27;
    localparam logic [5:0] OP_BGE   = 6'd28;
    localparam logic [5:0] OP_BHS   = 6'd29;
    localparam logic [5:0] OP_CMP   = 6'd30;
    localparam logic [5:0] OP_CMPI  = 6'd31;
    localparam logic [5:0] OP_MOV   = 6'd32;

    // Link register used by BL
    localparam logic [4:0] LINK_REG = 5'd30;

    typedef struct packed {
        logic        [5:0]  opcode;
        logic        [4:0]  dest_index;
        logic        [4:0]  first_source;
        logic        [4:0]  second_source;
        logic signed [31:0] immediate_value;
        logic        [31:0] target_address;
        logic        [31:0] current_pc;
    } lxu_req_t;

    typedef struct packed {
        logic signed [63:0] write_value;
        logic               write_enable;
        logic        [4:0]  write_index;
        logic               branch_taken;
        logic        [31:0] next_target;
        logic        [3:0]  flag_bits;
    } lxu_rsp_t;

    // Register file write port
    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [63:0] data;
    } lxu_wr_t;

endpackage

// File: hw/rtl/legv8_integer_execute_unit_top.sv
// Integer execute unit: takes one decoded instruction per request and returns one
// response with the register write, the branch decision and the NZCV flags after it.
// Throughput is one request per clock unless the response side stalls; a request
// register feeds a response register. Source registers are read from the register
// file memory when a request is accepted, with the write of the instruction executing
// in that same cycle forwarded, so dependent instructions may follow back to back. The
// execute path is one 64-bit adder (shared by add, subtract and compare), logic ops,
// a barrel shifter and the branch condition check. The register file is cleared by
// per-entry valid bits at reset, so no clearing pass is needed and requests are taken
// right after reset. A stall on the response side holds one request in the request
// register; new requests are accepted in the cycle the response register drains.
module legv8_integer_execute_unit_top import lxu_pkg::*; #(
    parameter int REG_COUNT = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  lxu_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lxu_rsp_t rsp_data
);

    lxu_req_t    req_reg;
    logic        req_valid_reg;
    lxu_rsp_t    rsp_reg;
    logic        rsp_valid_reg;
    logic [3:0]  flags_reg;

    logic        accept;
    logic        fire;
    logic        test_dest;
    logic [4:0]  addr_b;
    logic [63:0] op_a;
    logic [63:0] op_b;
    lxu_wr_t     exec_wr;
    lxu_wr_t     rf_wr;
    lxu_rsp_t    exec_rsp;
    logic [3:0]  flags_next;

    // Execute when an instruction is held and the response slot is free or draining
    assign fire      = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || fire;
    assign accept    = req_valid && req_ready;

    // CBZ and CBNZ test the destination register on the second read port
    assign test_dest = (req_data.opcode == OP_CBZ) || (req_data.opcode == OP_CBNZ);
    assign addr_b    = test_dest ? req_data.dest_index : req_data.second_source;

    assign rf_wr.en   = exec_wr.en && fire;
    assign rf_wr.idx  = exec_wr.idx;
    assign rf_wr.data = exec_wr.data;

    lxu_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (req_data.first_source),
        .rd_addr_b (addr_b),
        .wr        (rf_wr),
        .rd_data_a (op_a),
        .rd_data_b (op_b)
    );

    lxu_exec #(
        .REG_COUNT (REG_COUNT)
    ) u_exec (
        .req        (req_reg),
        .op_a       (op_a),
        .op_b       (op_b),
        .flags      (flags_reg),
        .rsp        (exec_rsp),
        .wr         (exec_wr),
        .flags_next (flags_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_data;
        end
        if (fire)
        begin
            rsp_reg <= exec_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= 4'd0;
        end
        else
        begin
            if (req_ready)
            begin
                req_valid_reg <= req_valid;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTHESIS
    // An executed instruction always leaves a response behind
    assert property (@(posedge clk) disable iff (!rst_n) fire |=> rsp_valid)
        else $error("executed request produced no response");

    // Register writes only go to implemented registers
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> ({1'b0, rf_wr.idx} < 6'(REG_COUNT)))
        else $error("write to register beyond register count");

    // Flags in a response match the flag state it leaves behind
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (rsp_data.flag_bits == flags_reg))
        else $error("response flags differ from flag state");

    // Without a write, value and index read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_data.write_enable) |->
        ((rsp_data.write_value == 64'd0) && (rsp_data.write_index == 5'd0)))
        else $error("response carries write data with no write");
`endif

endmodule

// File: hw/rtl/lxu_regfile.sv
module lxu_regfile import lxu_pkg::*; #(
    parameter int REG_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  rd_addr_a,
    input  logic [4:0]  rd_addr_b,
    input  lxu_wr_t     wr,
    output logic [63:0] rd_data_a,
    output logic [63:0] rd_data_b
);

    localparam int         IDX_W     = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    logic [63:0]          rf_reg [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [63:0]          rdata_a_reg;
    logic [63:0]          rdata_b_reg;
    logic [63:0]          fwd_data_reg;
    logic                 fwd_a_reg;
    logic                 fwd_b_reg;
    logic                 live_a_reg;
    logic                 live_b_reg;

    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] wr_idx;
    logic             live_a;
    logic             live_b;
    logic             hit_a;
    logic             hit_b;

    assign idx_a  = rd_addr_a[IDX_W-1:0];
    assign idx_b  = rd_addr_b[IDX_W-1:0];
    assign wr_idx = wr.idx[IDX_W-1:0];

    // Entries beyond the register count, or never written, read as zero
    assign live_a = ({1'b0, rd_addr_a} < REG_LIMIT) && valid_reg[idx_a];
    assign live_b = ({1'b0, rd_addr_b} < REG_LIMIT) && valid_reg[idx_b];

    // Forward the write landing in the same cycle as the read
    assign hit_a = wr.en && (wr.idx == rd_addr_a);
    assign hit_b = wr.en && (wr.idx == rd_addr_b);

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            rf_reg[wr_idx] <= wr.data;
        end
        if (rd_en)
        begin
            rdata_a_reg  <= rf_reg[idx_a];
            rdata_b_reg  <= rf_reg[idx_b];
            fwd_data_reg <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fwd_a_reg  <= 1'b0;
            fwd_b_reg  <= 1'b0;
            live_a_reg <= 1'b0;
            live_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                fwd_a_reg  <= hit_a;
                fwd_b_reg  <= hit_b;
                live_a_reg <= live_a;
                live_b_reg <= live_b;
            end
        end
    end

    assign rd_data_a = fwd_a_reg ? fwd_data_reg : (live_a_reg ? rdata_a_reg : '0);
    assign rd_data_b = fwd_b_reg ? fwd_data_reg : (live_b_reg ? rdata_b_reg : '0);

endmodule

// File: hw/rtl/lxu_exec.sv
module lxu_exec import lxu_pkg::*; #(
    parameter int REG_COUNT = 32
) (
    input  lxu_req_t    req,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    input  logic [3:0]  flags,
    output lxu_rsp_t    rsp,
    output lxu_wr_t     wr,
    output logic [3:0]  flags_next
);

    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    logic [63:0] imm64;
    logic [5:0]  sh;
    logic        use_imm;
    logic        is_sub;
    logic [63:0] opnd;
    logic [63:0] addend;
    logic [64:0] sum;
    logic [63:0] res;
    logic [3:0]  arith_flags;
    logic [63:0] and_res;
    logic [3:0]  logic_flags;
    logic        fn;
    logic        fz;
    logic        fc;
    logic        fv;
    logic [63:0] val;
    logic        wr_req;
    logic        wr_ok;
    logic [4:0]  widx;
    logic        taken;
    logic [31:0] next;

    assign imm64 = {{32{req.immediate_value[31]}}, req.immediate_value};
    assign sh    = req.immediate_value[5:0];

    assign use_imm = (req.opcode == OP_ADDI)  || (req.opcode == OP_ADDIS) ||
                     (req.opcode == OP_ANDI)  || (req.opcode == OP_ANDIS) ||
                     (req.opcode == OP_EORI)  || (req.opcode == OP_ORRI)  ||
                     (req.opcode == OP_SUBI)  || (req.opcode == OP_SUBIS) ||
                     (req.opcode == OP_CMPI);
    assign is_sub  = (req.opcode == OP_SUB)   || (req.opcode == OP_SUBS)  ||
                     (req.opcode == OP_SUBI)  || (req.opcode == OP_SUBIS) ||
                     (req.opcode == OP_CMP)   || (req.opcode == OP_CMPI);

    // Shared adder: subtract is a + ~b + 1, carry out is "no borrow"
    assign opnd   = use_imm ? imm64 : op_b;
    assign addend = is_sub ? ~opnd : opnd;
    assign sum    = {1'b0, op_a} + {1'b0, addend} + {64'd0, is_sub};
    assign res    = sum[63:0];
    assign arith_flags = {res[63], (res == 64'd0), sum[64],
                          ~(op_a[63] ^ addend[63]) & (op_a[63] ^ res[63])};

    assign and_res     = op_a & opnd;
    assign logic_flags = {and_res[63], (and_res == 64'd0), 2'b00};

    assign fn = flags[3];
    assign fz = flags[2];
    assign fc = flags[1];
    assign fv = flags[0];

    always_comb
    begin
        val        = '0;
        wr_req     = 1'b0;
        widx       = req.dest_index;
        taken      = 1'b0;
        next       = req.target_address;
        flags_next = flags;
        case (req.opcode)
            OP_ADD, OP_ADDI, OP_SUB, OP_SUBI:
            begin
                val    = res;
                wr_req = 1'b1;
            end
            OP_ADDS, OP_ADDIS, OP_SUBS, OP_SUBIS:
            begin
                val        = res;
                wr_req     = 1'b1;
                flags_next = arith_flags;
            end
            OP_AND, OP_ANDI:
            begin
                val    = and_res;
                wr_req = 1'b1;
            end
            OP_ANDS, OP_ANDIS:
            begin
                val        = and_res;
                wr_req     = 1'b1;
                flags_next = logic_flags;
            end
            OP_EOR, OP_EORI:
            begin
                val    = op_a ^ opnd;
                wr_req = 1'b1;
            end
            OP_ORR, OP_ORRI:
            begin
                val    = op_a | opnd;
                wr_req = 1'b1;
            end
            OP_LSL:
            begin
                val    = op_a << sh;
                wr_req = 1'b1;
            end
            OP_LSR:
            begin
                val    = op_a >> sh;
                wr_req = 1'b1;
            end
            OP_MOV:
            begin
                val    = op_a;
                wr_req = 1'b1;
            end
            OP_CMP, OP_CMPI:
            begin
                flags_next = arith_flags;
            end
            OP_BR:
            begin
                taken = 1'b1;
                next  = op_a[31:0];
            end
            OP_B:
            begin
                taken = 1'b1;
            end
            OP_BL:
            begin
                taken  = 1'b1;
                val    = {32'd0, req.current_pc};
                widx   = LINK_REG;
                wr_req = 1'b1;
            end
            OP_CBZ:  taken = (op_b == 64'd0);
            OP_CBNZ: taken = (op_b != 64'd0);
            OP_BNE:  taken = !fz;
            OP_BEQ:  taken = fz;
            OP_BLT:  taken = (fn != fv);
            OP_BLE:  taken = fz || (fn != fv);
            OP_BGT:  taken = !fz && (fn == fv);
            OP_BGE:  taken = (fn == fv);
            OP_BHS:  taken = fc;
            default:
            begin
                taken = 1'b0;
            end
        endcase
    end

    // Writes to registers beyond the register count are dropped
    assign wr_ok = wr_req && ({1'b0, widx} < REG_LIMIT);

    assign wr.en   = wr_ok;
    assign wr.idx  = widx;
    assign wr.data = val;

    assign rsp.write_value  = wr_ok ? val : '0;
    assign rsp.write_enable = wr_ok;
    assign rsp.write_index  = wr_ok ? widx : '0;
    assign rsp.branch_taken = taken;
    assign rsp.next_target  = taken ? next : '0;
    assign rsp.flag_bits    = flags_next;

endmodule
